// ===== rtl/rcm_pkg.sv =====
// Package for the rank counting multiset: sizes, opcodes, the cell control
// bus and the controller state type. No dependencies.
`default_nettype none

package rcm_pkg;

  // Store depth and derived widths
  localparam int CAPACITY = 1024;
  localparam int CW       = $clog2(CAPACITY + 1);   // count / occupancy width
  localparam int IW       = $clog2(CAPACITY);       // cell index width
  localparam int VW       = 32;                     // stored value width

  // Adder tree shape: radix-4 heap over the cell hit bits
  localparam int RADIX = 4;

  function automatic int tree_levels(input int leaves);
    int lv;
    int span;
    lv   = 0;
    span = 1;
    while (span < leaves) begin
      span = span * RADIX;
      lv   = lv + 1;
    end
    return lv;
  endfunction

  localparam int LVLS      = tree_levels(CAPACITY);
  localparam int LEAF_PAD  = RADIX ** LVLS;
  localparam int INT_NODES = (LEAF_PAD - 1) / (RADIX - 1);
  localparam int CNT_W     = $clog2(LVLS + 2);

  // Opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic                 shift;  // insert: every cell takes its left neighbor
    logic [CW-1:0]        occ;    // cells below this index hold live values
    logic signed [VW-1:0] probe;  // query value
  } cell_bus_t;

  typedef enum logic {
    ST_IDLE,
    ST_RANK
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/rcm_cell.sv =====
// One storage cell of the value chain: holds a value, hands it right on an
// insert, and flags whether it is live and not above the probe.
// Depends on rcm_pkg.
`default_nettype none

module rcm_cell import rcm_pkg::*; (
  input  logic                 clk,
  input  cell_bus_t            bus_i,
  input  logic [IW-1:0]        idx_i,
  input  logic signed [VW-1:0] din_i,
  output logic signed [VW-1:0] dout_o,
  output logic                 hit_o
);

  logic signed [VW-1:0] value_r;
  logic                 hit_r;

  // Shift register stage
  always_ff @(posedge clk) begin
    if (bus_i.shift) begin
      value_r <= din_i;
    end
  end

  // Live-and-not-greater flag, registered as a tree leaf
  always_ff @(posedge clk) begin
    hit_r <= (CW'(idx_i) < bus_i.occ) && (value_r <= $signed(bus_i.probe));
  end

  assign dout_o = value_r;
  assign hit_o  = hit_r;

endmodule

`default_nettype wire

// ===== rtl/rcm_tree.sv =====
// Registered radix-4 adder tree that counts the cell hit bits, with a
// register at every level. Depends on rcm_pkg.
`default_nettype none

module rcm_tree import rcm_pkg::*; (
  input  logic                clk,
  input  logic [CAPACITY-1:0] hit_i,
  output logic [CW-1:0]       sum_o
);

  logic [CW-1:0] node [INT_NODES];

  // Heap layout: node p has children RADIX*p+1 .. RADIX*p+RADIX,
  // indices at or past INT_NODES are leaves (padding leaves read zero)
  for (genvar p = 0; p < INT_NODES; p++) begin : g_node
    logic [CW-1:0] kid [RADIX];
    logic [CW-1:0] add;
    logic [CW-1:0] node_r;

    for (genvar k = 0; k < RADIX; k++) begin : g_kid
      localparam int C = RADIX * p + 1 + k;
      if (C < INT_NODES) begin : g_int
        assign kid[k] = node[C];
      end else if (C - INT_NODES < CAPACITY) begin : g_leaf
        assign kid[k] = CW'(hit_i[C - INT_NODES]);
      end else begin : g_pad
        assign kid[k] = '0;
      end
    end

    always_comb begin
      add = '0;
      for (int k = 0; k < RADIX; k++) begin
        add = CW'(add + kid[k]);
      end
    end

    always_ff @(posedge clk) begin
      node_r <= add;
    end

    assign node[p] = node_r;
  end

  assign sum_o = node[0];

endmodule

`default_nettype wire

// ===== rtl/rank_count_multiset.sv =====
// Rank counting multiset: a shift chain of value cells, a registered
// adder tree for rank queries and the handshake controller.
// Depends on rcm_pkg, rcm_cell and rcm_tree.
//
// Usage:
//   Input beat: in_opcode/in_value under in_valid, held back by in_stall.
//   Opcodes: insert value, count stored values <= value (signed), clear.
//   Output beat: out_count/out_status under out_valid, held by out_stall.
//   Each input beat gives exactly one output beat, in order.
// Timing and throughput:
//   Insert, clear and the unused opcode land in the output register at the
//   accepting edge, one beat per cycle while the output drains. A query
//   passes the registered per-cell compare, then one register per level of
//   the radix-4 adder tree, then the output register; the block takes no new
//   beat until the query result is in the output register. Inserts shift the
//   whole chain at the accepting edge.
// Reset: occupancy and all handshake state clear; stored values are not
//   cleared, only cells below the occupancy count ever contribute.
// Stall: a stalled output beat holds; the block keeps accepting one more
//   beat only once the output register is free or being drained.
`default_nettype none

module rank_count_multiset import rcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic signed [VW-1:0] in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CW-1:0]        out_count,
  output logic                 out_status
);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]        occ_r, occ_nxt;
  logic signed [VW-1:0] probe_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;
  logic                 out_status_r, out_status_nxt;

  logic                 out_free;
  logic                 accept;
  logic                 do_shift;
  cell_bus_t            bus;
  logic signed [VW-1:0] chain [CAPACITY+1];
  logic [CAPACITY-1:0]  hit;
  logic [CW-1:0]        rank;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign do_shift = accept && (in_opcode == OP_INSERT) && (occ_r != CW'(CAPACITY));

  // Cell chain: newest value enters cell 0
  assign bus.shift = do_shift;
  assign bus.occ   = occ_r;
  assign bus.probe = probe_r;
  assign chain[0]  = in_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rcm_cell u_cell (
      .clk    (clk),
      .bus_i  (bus),
      .idx_i  (IW'(i)),
      .din_i  (chain[i]),
      .dout_o (chain[i+1]),
      .hit_o  (hit[i])
    );
  end

  rcm_tree u_tree (
    .clk   (clk),
    .hit_i (hit),
    .sum_o (rank)
  );

  // Probe latch for queries
  always_ff @(posedge clk) begin
    if (accept) begin
      probe_r <= in_value;
    end
  end

  // Control and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  // Next state, occupancy and result
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (occ_r == CW'(CAPACITY)) begin
                out_count_nxt  = occ_r;
                out_status_nxt = 1'b1;
              end else begin
                occ_nxt        = CW'(occ_r + 1'b1);
                out_count_nxt  = CW'(occ_r + 1'b1);
                out_status_nxt = 1'b0;
              end
            end
            OP_QUERY: begin
              state_nxt = ST_RANK;
              cnt_nxt   = CNT_W'(LVLS + 1);
            end
            OP_CLEAR: begin
              occ_nxt        = '0;
              out_valid_nxt  = 1'b1;
              out_count_nxt  = '0;
              out_status_nxt = 1'b0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_count_nxt  = occ_r;
              out_status_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_RANK: begin
        // wait for the compare stage and the tree levels, then post
        if (cnt_r != '0) begin
          cnt_nxt = CNT_W'(cnt_r - 1'b1);
        end else if (out_free) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_count_nxt  = rank;
          out_status_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/rcm_checker.sv =====
// Port-level checks for the rank counting multiset and the bind that
// attaches them to the top level. Depends on rcm_pkg.
`default_nettype none

module rcm_checker import rcm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [1:0]           in_opcode,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [CW-1:0]        out_count,
  input logic                 out_status
);

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat valid after reset");

  // A dropped insert only happens at a full store
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_count == CW'(CAPACITY))
    else $error("drop flagged below capacity");

  // A count never exceeds the store depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CW'(CAPACITY))
    else $error("count beyond capacity");

  // A clear beat is answered next cycle with zero
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == OP_CLEAR
    |=> out_valid && out_count == '0 && !out_status)
    else $error("clear did not report an empty store");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count) && $stable(out_status))
    else $error("stalled output beat changed");

endmodule

bind rank_count_multiset rcm_checker u_rcm_checker (.*);

`default_nettype wire
